// File: design/detsch_pkg.sv
// Shared types, constants and codes of the delayed event timer scheduler.
`timescale 1ns / 1ps
`default_nettype none

package detsch_pkg;

  // Sizes of the three delay tables (all share one cell row layout) and the queue
  localparam int unsigned TBL_SLOTS   = 16;
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QFILL_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned REMAIN_W    = 32;
  localparam int unsigned AMOUNT_W    = 16;
  localparam int unsigned DIV_W       = 32;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_W);

  // Register reset values
  localparam logic [15:0] SHORT_LIM_RST = 16'd2000;
  localparam logic [31:0] MED_LIM_RST   = 32'd60000;
  localparam logic [31:0] SEC_DAY_RST   = 32'd86400;

  // Tick arithmetic
  localparam logic [15:0] MS_PER_SEC  = 16'd1000;
  localparam logic [15:0] CENTI_DIV   = 16'd10;
  localparam logic [15:0] DECI_DIV    = 16'd100;
  // floor(d/10) = (d * 0xCCCCCCCD) >> 35 and floor(d/100) = (d * 0x51EB851F) >> 37
  // for 32-bit d
  localparam logic [31:0] CENTI_RECIP32 = 32'hCCCCCCCD;
  localparam logic [31:0] DECI_RECIP32  = 32'h51EB851F;
  localparam int unsigned CENTI_SHIFT32 = 35;
  localparam int unsigned DECI_SHIFT32  = 37;
  // floor(r/10) = (r * 52429) >> 19 and floor(r/100) = (r * 83887) >> 23 for 16-bit r
  localparam logic [15:0] CENTI_RECIP = 16'd52429;
  localparam logic [16:0] DECI_RECIP  = 17'd83887;
  localparam int unsigned CENTI_SHIFT = 19;
  localparam int unsigned DECI_SHIFT  = 23;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_POLL   = 2'd1,
    KIND_SCHED  = 2'd2,
    KIND_CANCEL = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_USER  = 3'd1,
    EV_CENTI = 3'd2,
    EV_DECI  = 3'd3,
    EV_SEC   = 3'd4,
    EV_DAY   = 3'd5
  } ev_kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_TBL_FULL  = 2'd2,
    STAT_Q_OVF     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_SHORT_LIM = 2'd0,
    CFG_MED_LIM   = 2'd1,
    CFG_SEC_DAY   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    TOP_NONE,
    TOP_SUB,
    TOP_POP,
    TOP_COMPACT,
    TOP_APPEND,
    TOP_CANCEL
  } tbl_op_e;

  typedef enum logic [1:0] {
    TBL_S,
    TBL_M,
    TBL_L
  } tbl_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_DRAIN,
    S_COMPACT,
    S_POLL_MUL,
    S_POLL_DEC,
    S_SEC_DIV,
    S_CANCEL,
    S_ROUTE,
    S_DIV_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    tbl_op_e               op;
    logic [AMOUNT_W-1:0]   amount;
    logic [REMAIN_W-1:0]   remain;
    logic [7:0]            code;
    logic [15:0]           param;
  } tbl_ctrl_t;

  typedef struct packed {
    logic        full;
    logic        exp_any;
    logic        compact;
    logic        found;
    logic [7:0]  pop_code;
    logic [15:0] pop_param;
  } tbl_stat_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic        day;
    logic [7:0]  code;
    logic [15:0] param;
  } q_entry_t;

endpackage

`default_nettype wire

// File: design/delayed_event_timer_scheduler_core.sv
// Top level: tick residues, three delay tables, ready queue and the item sequencer.
//
// Usage: items enter on in_valid_i/in_ready_o (kind, elapsed_ms, delay_ms, event_code,
// event_param, force_req); every item gives exactly one result on out_valid_o/out_ready_i
// (event_kind, out_code, out_param, status). Registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i in one cycle, while no item is in flight.
// One item is in work at a time; in_ready_o is high whenever the sequencer is idle, also
// while the previous result still sits in the output register.
// States passed from accept to result valid, every path ending in S_DONE; S_DRAIN pops
// one expired entry per cycle, and S_COMPACT repeats until all three tables are compact:
//   tick: S_TICK, then S_DRAIN and S_COMPACT unless elapsed is zero; cancel: S_CANCEL,
//   S_COMPACT; schedule: S_CANCEL, S_COMPACT unless forced, then S_ROUTE, then S_DIV_WAIT
//   for a centisecond or decisecond table entry (delay scaled by a registered reciprocal
//   multiply); poll: S_POLL_MUL, S_POLL_DEC, then S_DRAIN and S_COMPACT for a counted
//   tick, S_SEC_DIV for a second tick when the day length is not zero (day check runs
//   through the serial divider).
// Reset empties all tables and the queue, clears the residues and the seconds count and
// loads the register defaults. If out_ready_i is low, the finished result is held and the
// sequencer waits after the next item until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module delayed_event_timer_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] elapsed_ms_i,
  input  logic [31:0] delay_ms_i,
  input  logic [7:0]  event_code_i,
  input  logic signed [15:0] event_param_i,
  input  logic        force_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_kind_o,
  output logic [7:0]  out_code_o,
  output logic signed [15:0] out_param_o,
  output logic [1:0]  status_o
);
  import detsch_pkg::*;

  state_e      state_q, state_d;
  logic        out_valid_q;
  logic [15:0] short_lim_q;
  logic [31:0] med_lim_q, sec_day_q;
  logic [15:0] centi_q, centi_d, deci_q, deci_d, sec_q, sec_d;
  logic [31:0] secs_q, secs_d;
  tbl_sel_e    drain_sel_q, drain_sel_d;
  logic        route_mid_q, route_mid_d;

  // Latched item
  kind_e       kind_q;
  logic [15:0] elapsed_q;
  logic [31:0] delay_q;
  logic [7:0]  ecode_q;
  logic [15:0] eparam_q;

  // Result under construction and output register
  ev_kind_e    res_ev_q, res_ev_d;
  logic [7:0]  res_code_q, res_code_d;
  logic [15:0] res_param_q, res_param_d;
  status_e     res_stat_q, res_stat_d;
  ev_kind_e    out_ev_q;
  logic [7:0]  out_code_q;
  logic [15:0] out_param_q;
  status_e     out_stat_q;

  logic [31:0] prod_c_q;
  logic [32:0] prod_d_q;
  logic [12:0] n_c;
  logic [9:0]  n_d;

  // Delay scaling for the centisecond and decisecond tables
  logic [31:0] route_recip;
  logic [63:0] prod_r_q;

  logic        in_acc, out_load;

  tbl_ctrl_t   ctrl_base, ctrl_s, ctrl_m, ctrl_l;
  tbl_stat_t   stat_s, stat_m, stat_l, stat_sel;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  // Ready queue
  q_entry_t           qmem [QUEUE_DEPTH];
  q_entry_t           q_rd_q, push_ent;
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QFILL_W-1:0] fill_q;
  logic               push_req, push_ok, pop, q_full;

  detsch_table u_short (.clk_i, .rst_ni, .ctrl_i(ctrl_s), .stat_o(stat_s));
  detsch_table u_mid   (.clk_i, .rst_ni, .ctrl_i(ctrl_m), .stat_o(stat_m));
  detsch_table u_long  (.clk_i, .rst_ni, .ctrl_i(ctrl_l), .stat_o(stat_l));
  detsch_div   u_div   (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign q_full      = (fill_q == QFILL_W'(QUEUE_DEPTH));
  assign push_ok     = push_req && !q_full;
  assign n_c         = prod_c_q[31:CENTI_SHIFT];
  assign n_d         = prod_d_q[32:DECI_SHIFT];
  assign route_recip = (delay_q < med_lim_q) ? CENTI_RECIP32 : DECI_RECIP32;

  always_comb begin
    ctrl_base.op     = TOP_NONE;
    ctrl_base.amount = '0;
    ctrl_base.remain = delay_q;
    ctrl_base.code   = ecode_q;
    ctrl_base.param  = eparam_q;
  end

  always_comb begin
    unique case (drain_sel_q)
      TBL_S:   stat_sel = stat_s;
      TBL_M:   stat_sel = stat_m;
      default: stat_sel = stat_l;
    endcase
  end

  // Sequencer: next state, table commands, queue and divider requests
  always_comb begin
    state_d     = state_q;
    centi_d     = centi_q;
    deci_d      = deci_q;
    sec_d       = sec_q;
    secs_d      = secs_q;
    drain_sel_d = drain_sel_q;
    route_mid_d = route_mid_q;
    res_ev_d    = res_ev_q;
    res_code_d  = res_code_q;
    res_param_d = res_param_q;
    res_stat_d  = res_stat_q;
    ctrl_s      = ctrl_base;
    ctrl_m      = ctrl_base;
    ctrl_l      = ctrl_base;
    push_req    = 1'b0;
    push_ent    = '0;
    pop         = 1'b0;
    div_req     = '0;
    out_load    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        res_ev_d    = EV_NONE;
        res_code_d  = '0;
        res_param_d = '0;
        res_stat_d  = STAT_OK;
        if (in_valid_i) begin
          unique case (kind_e'(kind_i))
            KIND_TICK:  state_d = S_TICK;
            KIND_POLL:  state_d = S_POLL_MUL;
            KIND_SCHED: state_d = force_req_i ? S_ROUTE : S_CANCEL;
            default:    state_d = S_CANCEL;
          endcase
        end
      end

      // Count the millisecond table down and advance the residues, unless elapsed is zero
      S_TICK: begin
        if (elapsed_q == '0) begin
          state_d = S_DONE;
        end else begin
          ctrl_s.op     = TOP_SUB;
          ctrl_s.amount = elapsed_q;
          centi_d       = centi_q + elapsed_q;
          deci_d        = deci_q + elapsed_q;
          sec_d         = sec_q + elapsed_q;
          drain_sel_d   = TBL_S;
          state_d       = S_DRAIN;
        end
      end

      // Move expired entries to the queue, first cell first
      S_DRAIN: begin
        if (stat_sel.exp_any) begin
          unique case (drain_sel_q)
            TBL_S:   ctrl_s.op = TOP_POP;
            TBL_M:   ctrl_m.op = TOP_POP;
            default: ctrl_l.op = TOP_POP;
          endcase
          push_req       = 1'b1;
          push_ent.day   = 1'b0;
          push_ent.code  = stat_sel.pop_code;
          push_ent.param = stat_sel.pop_param;
          if (q_full) begin
            res_stat_d = STAT_Q_OVF;
          end
        end else begin
          state_d = S_COMPACT;
        end
      end

      // Close holes left by expiry or cancel
      S_COMPACT: begin
        ctrl_s.op = TOP_COMPACT;
        ctrl_m.op = TOP_COMPACT;
        ctrl_l.op = TOP_COMPACT;
        if (stat_s.compact && stat_m.compact && stat_l.compact) begin
          state_d = (kind_q == KIND_SCHED) ? S_ROUTE : S_DONE;
        end
      end

      S_POLL_MUL: begin
        state_d = S_POLL_DEC;
      end

      // Pick the highest-priority event
      S_POLL_DEC: begin
        if (centi_q >= CENTI_DIV) begin
          centi_d       = centi_q - 16'(16'(n_c) * CENTI_DIV);
          ctrl_m.op     = TOP_SUB;
          ctrl_m.amount = AMOUNT_W'(n_c);
          res_ev_d      = EV_CENTI;
          res_param_d   = 16'(n_c);
          drain_sel_d   = TBL_M;
          state_d       = S_DRAIN;
        end else if (deci_q >= DECI_DIV) begin
          deci_d        = deci_q - 16'(16'(n_d) * DECI_DIV);
          ctrl_l.op     = TOP_SUB;
          ctrl_l.amount = AMOUNT_W'(n_d);
          res_ev_d      = EV_DECI;
          res_param_d   = 16'(n_d);
          drain_sel_d   = TBL_L;
          state_d       = S_DRAIN;
        end else if (sec_q >= MS_PER_SEC) begin
          sec_d    = sec_q - MS_PER_SEC;
          secs_d   = secs_q + 32'd1;
          res_ev_d = EV_SEC;
          if (sec_day_q == '0) begin
            // Zero day length wraps at 2^32
            if (secs_q == '1) begin
              push_req     = 1'b1;
              push_ent.day = 1'b1;
              if (q_full) begin
                res_stat_d = STAT_Q_OVF;
              end
            end
            state_d = S_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = secs_q + 32'd1;
            div_req.divisor  = sec_day_q;
            state_d          = S_SEC_DIV;
          end
        end else if (fill_q != '0) begin
          pop = 1'b1;
          if (q_rd_q.day) begin
            res_ev_d = EV_DAY;
          end else begin
            res_ev_d    = EV_USER;
            res_code_d  = q_rd_q.code;
            res_param_d = q_rd_q.param;
          end
          state_d = S_DONE;
        end else begin
          state_d = S_DONE;
        end
      end

      // Queue a day event when the seconds count hits a multiple of the day
      S_SEC_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem == '0) begin
            push_req     = 1'b1;
            push_ent.day = 1'b1;
            if (q_full) begin
              res_stat_d = STAT_Q_OVF;
            end
          end
          state_d = S_DONE;
        end
      end

      // Drop the first entry with this code, short table first
      S_CANCEL: begin
        if (stat_s.found) begin
          ctrl_s.op = TOP_CANCEL;
        end else if (stat_m.found) begin
          ctrl_m.op = TOP_CANCEL;
        end else if (stat_l.found) begin
          ctrl_l.op = TOP_CANCEL;
        end else if (kind_q == KIND_CANCEL) begin
          res_stat_d = STAT_NOT_FOUND;
        end
        state_d = S_COMPACT;
      end

      // Send a schedule request to the queue or a table
      S_ROUTE: begin
        if (delay_q == '0) begin
          push_req       = 1'b1;
          push_ent.day   = 1'b0;
          push_ent.code  = ecode_q;
          push_ent.param = eparam_q;
          if (q_full) begin
            res_stat_d = STAT_Q_OVF;
          end
          state_d = S_DONE;
        end else if (delay_q < {16'd0, short_lim_q}) begin
          if (stat_s.full) begin
            res_stat_d = STAT_TBL_FULL;
          end else begin
            ctrl_s.op = TOP_APPEND;
          end
          state_d = S_DONE;
        end else begin
          route_mid_d = delay_q < med_lim_q;
          state_d     = S_DIV_WAIT;
        end
      end

      // Append the scaled delay once the product register holds it
      S_DIV_WAIT: begin
        if (route_mid_q) begin
          if (stat_m.full) begin
            res_stat_d = STAT_TBL_FULL;
          end else begin
            ctrl_m.op     = TOP_APPEND;
            ctrl_m.remain = REMAIN_W'(prod_r_q[63:CENTI_SHIFT32]);
          end
        end else begin
          if (stat_l.full) begin
            res_stat_d = STAT_TBL_FULL;
          end else begin
            ctrl_l.op     = TOP_APPEND;
            ctrl_l.remain = REMAIN_W'(prod_r_q[63:DECI_SHIFT32]);
          end
        end
        state_d = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      short_lim_q <= SHORT_LIM_RST;
      med_lim_q   <= MED_LIM_RST;
      sec_day_q   <= SEC_DAY_RST;
      centi_q     <= '0;
      deci_q      <= '0;
      sec_q       <= '0;
      secs_q      <= '0;
      drain_sel_q <= TBL_S;
      route_mid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      centi_q     <= centi_d;
      deci_q      <= deci_d;
      sec_q       <= sec_d;
      secs_q      <= secs_d;
      drain_sel_q <= drain_sel_d;
      route_mid_q <= route_mid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SHORT_LIM: short_lim_q <= cfg_data_i[15:0];
          CFG_MED_LIM:   med_lim_q   <= cfg_data_i;
          CFG_SEC_DAY:   sec_day_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Item latch, result and residue products
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q    <= kind_e'(kind_i);
      elapsed_q <= elapsed_ms_i;
      delay_q   <= delay_ms_i;
      ecode_q   <= event_code_i;
      eparam_q  <= event_param_i;
    end
    res_ev_q    <= res_ev_d;
    res_code_q  <= res_code_d;
    res_param_q <= res_param_d;
    res_stat_q  <= res_stat_d;
    prod_c_q    <= 32'(centi_q) * 32'(CENTI_RECIP);
    prod_d_q    <= 33'(deci_q) * 33'(DECI_RECIP);
    prod_r_q    <= 64'(delay_q) * 64'(route_recip);
    if (out_load) begin
      out_ev_q    <= res_ev_q;
      out_code_q  <= res_code_q;
      out_param_q <= res_param_q;
      out_stat_q  <= res_stat_q;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      fill_q <= fill_q + QFILL_W'(push_ok) - QFILL_W'(pop);
    end
  end

  // Queue storage with registered head read
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      qmem[wr_ptr_q] <= push_ent;
    end
    q_rd_q <= qmem[rd_ptr_q];
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_ev_q;
  assign out_code_o   = out_code_q;
  assign out_param_o  = out_param_q;
  assign status_o     = out_stat_q;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= QFILL_W'(QUEUE_DEPTH))
    else $error("queue fill above depth");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_SEC_DIV))
    else $error("divider finished with no waiting state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted item did not start");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (fill_q != '0 && !push_req))
    else $error("pop from empty queue or with push");
`endif

endmodule

`default_nettype wire

// File: design/detsch_table.sv
// Delay table: a row of timer cells kept in insertion order, compacted by neighbor shifts.
`timescale 1ns / 1ps
`default_nettype none

module detsch_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  detsch_pkg::tbl_ctrl_t ctrl_i,
  output detsch_pkg::tbl_stat_t stat_o
);
  import detsch_pkg::*;

  logic [TBL_SLOTS-1:0] valid_q, exp_q;
  logic [REMAIN_W-1:0]  remain_q [TBL_SLOTS];
  logic [7:0]           code_q   [TBL_SLOTS];
  logic [15:0]          param_q  [TBL_SLOTS];

  // Neighbor data that each cell takes on a compaction step
  logic [REMAIN_W-1:0]  nrem   [TBL_SLOTS];
  logic [7:0]           ncode  [TBL_SLOTS];
  logic [15:0]          nparam [TBL_SLOTS];
  logic [TBL_SLOTS-1:0] valid_up, exp_up;

  logic [TBL_SLOTS-1:0] shift_sel, pick_exp, pick_match, pick_free, keep;
  logic                 hole, seen_e, seen_m, seen_f, gap;
  logic [7:0]           pop_code;
  logic [15:0]          pop_param;
  logic [REMAIN_W-1:0]  amount_ext;

  assign amount_ext = {{(REMAIN_W-AMOUNT_W){1'b0}}, ctrl_i.amount};
  assign valid_up   = {1'b0, valid_q[TBL_SLOTS-1:1]};
  assign exp_up     = {1'b0, exp_q[TBL_SLOTS-1:1]};

  for (genvar g = 0; g < TBL_SLOTS; g++) begin : g_link
    if (g == TBL_SLOTS - 1) begin : g_last
      assign nrem[g]   = '0;
      assign ncode[g]  = '0;
      assign nparam[g] = '0;
    end else begin : g_mid
      assign nrem[g]   = remain_q[g+1];
      assign ncode[g]  = code_q[g+1];
      assign nparam[g] = param_q[g+1];
    end
  end

  // Per-cell compare and first-of searches along the row
  always_comb begin
    hole      = 1'b0;
    seen_e    = 1'b0;
    seen_m    = 1'b0;
    seen_f    = 1'b0;
    pop_code  = '0;
    pop_param = '0;
    for (int i = 0; i < TBL_SLOTS; i++) begin
      hole          = hole | ~valid_q[i];
      shift_sel[i]  = hole;
      pick_exp[i]   = exp_q[i] & ~seen_e;
      seen_e        = seen_e | exp_q[i];
      pick_match[i] = valid_q[i] & (code_q[i] == ctrl_i.code) & ~seen_m;
      seen_m        = seen_m | (valid_q[i] & (code_q[i] == ctrl_i.code));
      pick_free[i]  = ~valid_q[i] & ~seen_f;
      seen_f        = seen_f | ~valid_q[i];
      keep[i]       = remain_q[i] > amount_ext;
      if (pick_exp[i]) begin
        pop_code  = pop_code | code_q[i];
        pop_param = pop_param | param_q[i];
      end
    end
  end

  // Row is compact when no empty cell sits below a filled one
  always_comb begin
    gap = 1'b0;
    for (int i = 0; i < TBL_SLOTS - 1; i++) begin
      gap = gap | (~valid_q[i] & valid_q[i+1]);
    end
  end

  assign stat_o.full      = &valid_q;
  assign stat_o.exp_any   = |exp_q;
  assign stat_o.compact   = ~gap;
  assign stat_o.found     = seen_m;
  assign stat_o.pop_code  = pop_code;
  assign stat_o.pop_param = pop_param;

  // Cell occupancy and expiry flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      exp_q   <= '0;
    end else begin
      unique case (ctrl_i.op)
        TOP_SUB: begin
          exp_q <= exp_q | (valid_q & ~keep);
        end
        TOP_POP: begin
          valid_q <= valid_q & ~pick_exp;
          exp_q   <= exp_q & ~pick_exp;
        end
        TOP_COMPACT: begin
          valid_q <= (valid_q & ~shift_sel) | (valid_up & shift_sel);
          exp_q   <= (exp_q & ~shift_sel) | (exp_up & shift_sel);
        end
        TOP_APPEND: begin
          valid_q <= valid_q | pick_free;
        end
        TOP_CANCEL: begin
          valid_q <= valid_q & ~pick_match;
        end
        default: ;
      endcase
    end
  end

  // Cell payload: count down, shift toward the head, load on append
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TBL_SLOTS; i++) begin
      case (ctrl_i.op)
        TOP_SUB: begin
          if (valid_q[i] && keep[i]) begin
            remain_q[i] <= remain_q[i] - amount_ext;
          end
        end
        TOP_COMPACT: begin
          if (shift_sel[i]) begin
            remain_q[i] <= nrem[i];
            code_q[i]   <= ncode[i];
            param_q[i]  <= nparam[i];
          end
        end
        TOP_APPEND: begin
          if (pick_free[i]) begin
            remain_q[i] <= ctrl_i.remain;
            code_q[i]   <= ctrl_i.code;
            param_q[i]  <= ctrl_i.param;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/detsch_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module detsch_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  detsch_pkg::div_req_t req_i,
  output detsch_pkg::div_rsp_t rsp_o
);
  import detsch_pkg::*;

  logic                 run_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     rem_q, quo_q, dvs_q;
  logic [DIV_W:0]       trial, diff;
  logic                 ge;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(DIV_W - 1);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (run_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

// File: sim/delayed_event_timer_scheduler_core_test.sv
// Testbench of the delayed event timer scheduler: random and directed items with a scoreboard.
`timescale 1ns / 1ps

module delayed_event_timer_scheduler_core_test;
  import detsch_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct {
    kind_e       kind;
    logic [15:0] elapsed;
    logic [31:0] delay;
    logic [7:0]  code;
    logic [15:0] param;
    logic        frc;
  } sched_req_t;

  typedef struct {
    ev_kind_e    ev;
    logic [7:0]  code;
    logic [15:0] param;
    status_e     status;
  } sched_res_t;

  typedef struct {
    logic [31:0] remain;
    logic [7:0]  code;
    logic [15:0] param;
  } timer_slot_t;

  // Timer state mirror and the queue of predicted events
  class event_sched_board;
    logic [15:0]  short_lim;
    logic [31:0]  med_lim;
    logic [31:0]  sec_day;
    logic [15:0]  centi_res, deci_res, sec_res;
    logic [31:0]  sec_cnt;
    timer_slot_t  short_tbl[$], mid_tbl[$], long_tbl[$];
    q_entry_t     ready_q[$];
    sched_res_t   pending_events[$];
    int unsigned  err_cnt;
    int unsigned  checked_cnt;

    function new();
      short_lim   = SHORT_LIM_RST;
      med_lim     = MED_LIM_RST;
      sec_day     = SEC_DAY_RST;
      centi_res   = '0;
      deci_res    = '0;
      sec_res     = '0;
      sec_cnt     = '0;
      err_cnt     = 0;
      checked_cnt = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] val);
      case (idx)
        CFG_SHORT_LIM: short_lim = val[15:0];
        CFG_MED_LIM:   med_lim = val;
        CFG_SEC_DAY:   sec_day = val;
        default: ;
      endcase
    endfunction

    // Queue an event; return 0 when the queue is full
    function bit push_ready(logic day, logic [7:0] code, logic [15:0] param);
      q_entry_t e;
      if (ready_q.size() >= QUEUE_DEPTH) return 0;
      e.day = day;
      e.code = code;
      e.param = param;
      ready_q.push_back(e);
      return 1;
    endfunction

    // Count a table down; return 1 on queue overflow
    function bit count_down(ref timer_slot_t tbl[$], input logic [31:0] amt);
      timer_slot_t kept[$];
      bit ovf;
      ovf = 0;
      foreach (tbl[i]) begin
        if (tbl[i].remain > amt) begin
          kept.push_back(tbl[i]);
          kept[$].remain = tbl[i].remain - amt;
        end else if (!push_ready(1'b0, tbl[i].code, tbl[i].param)) begin
          ovf = 1;
        end
      end
      tbl = kept;
      return ovf;
    endfunction

    function bit drop_code(ref timer_slot_t tbl[$], input logic [7:0] code);
      foreach (tbl[i]) begin
        if (tbl[i].code == code) begin
          tbl.delete(i);
          return 1;
        end
      end
      return 0;
    endfunction

    function bit cancel_first(logic [7:0] code);
      if (drop_code(short_tbl, code)) return 1;
      if (drop_code(mid_tbl, code)) return 1;
      return drop_code(long_tbl, code);
    endfunction

    function bit add_slot(ref timer_slot_t tbl[$], input logic [31:0] remain,
                          input logic [7:0] code, input logic [15:0] param);
      timer_slot_t s;
      if (tbl.size() >= TBL_SLOTS) return 0;
      s.remain = remain;
      s.code = code;
      s.param = param;
      tbl.push_back(s);
      return 1;
    endfunction

    // Work out the result of one accepted item and hold it
    function void accept(sched_req_t rq);
      sched_res_t r;
      logic [15:0] n;
      q_entry_t h;
      bit day, ok;
      r.ev = EV_NONE;
      r.code = '0;
      r.param = '0;
      r.status = STAT_OK;
      case (rq.kind)
        KIND_TICK: begin
          if (rq.elapsed != 0) begin
            if (count_down(short_tbl, {16'd0, rq.elapsed})) r.status = STAT_Q_OVF;
            centi_res += rq.elapsed;
            deci_res += rq.elapsed;
            sec_res += rq.elapsed;
          end
        end
        KIND_POLL: begin
          if (centi_res >= 10) begin
            n = centi_res / 10;
            centi_res = centi_res - n * 10;
            r.ev = EV_CENTI;
            r.param = n;
            if (count_down(mid_tbl, {16'd0, n})) r.status = STAT_Q_OVF;
          end else if (deci_res >= 100) begin
            n = deci_res / 100;
            deci_res = deci_res - n * 100;
            r.ev = EV_DECI;
            r.param = n;
            if (count_down(long_tbl, {16'd0, n})) r.status = STAT_Q_OVF;
          end else if (sec_res >= 1000) begin
            sec_res -= 1000;
            sec_cnt += 1;
            day = (sec_day == 0) ? (sec_cnt == 0) : (sec_cnt % sec_day == 0);
            r.ev = EV_SEC;
            if (day && !push_ready(1'b1, 8'd0, 16'd0)) r.status = STAT_Q_OVF;
          end else if (ready_q.size() > 0) begin
            h = ready_q.pop_front();
            if (h.day) begin
              r.ev = EV_DAY;
            end else begin
              r.ev = EV_USER;
              r.code = h.code;
              r.param = h.param;
            end
          end
        end
        KIND_SCHED: begin
          if (!rq.frc) void'(cancel_first(rq.code));
          if (rq.delay == 0) begin
            if (!push_ready(1'b0, rq.code, rq.param)) r.status = STAT_Q_OVF;
          end else begin
            if (rq.delay < {16'd0, short_lim})
              ok = add_slot(short_tbl, rq.delay, rq.code, rq.param);
            else if (rq.delay < med_lim)
              ok = add_slot(mid_tbl, rq.delay / 10, rq.code, rq.param);
            else
              ok = add_slot(long_tbl, rq.delay / 100, rq.code, rq.param);
            if (!ok) r.status = STAT_TBL_FULL;
          end
        end
        default: begin
          if (!cancel_first(rq.code)) r.status = STAT_NOT_FOUND;
        end
      endcase
      pending_events.push_back(r);
    endfunction

    // Compare one result with the oldest prediction
    function void check(sched_res_t act);
      sched_res_t e;
      checked_cnt++;
      if (pending_events.size() == 0) begin
        $error("result with no prediction waiting: kind %0d", act.ev);
        err_cnt++;
        return;
      end
      e = pending_events.pop_front();
      if (act.ev !== e.ev) begin
        $error("event_kind: expected %0d, got %0d", e.ev, act.ev);
        err_cnt++;
      end
      if (act.code !== e.code) begin
        $error("out_code: expected %0d, got %0d", e.code, act.code);
        err_cnt++;
      end
      if (act.param !== e.param) begin
        $error("out_param: expected %0d, got %0d", $signed(e.param), $signed(act.param));
        err_cnt++;
      end
      if (act.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, act.status);
        err_cnt++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [15:0] elapsed_ms_i;
  logic [31:0] delay_ms_i;
  logic [7:0]  event_code_i;
  logic signed [15:0] event_param_i;
  logic        force_req_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  event_kind_o;
  logic [7:0]  out_code_o;
  logic signed [15:0] out_param_o;
  logic [1:0]  status_o;

  event_sched_board board = new();
  int unsigned sent_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned poll_pct = 35;
  int unsigned zero_delay_pct = 10;

  delayed_event_timer_scheduler_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Draw an idle count; some stretches run with no idling at all
  function automatic int unsigned idle_draw(int unsigned n);
    if ((n / 40) % 4 == 1) return 0;
    return $urandom_range(0, 11);
  endfunction

  task automatic send_item(sched_req_t rq);
    int unsigned gap;
    gap = idle_draw(sent_cnt);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= rq.kind;
    elapsed_ms_i  <= rq.elapsed;
    delay_ms_i    <= rq.delay;
    event_code_i  <= rq.code;
    event_param_i <= rq.param;
    force_req_i   <= rq.frc;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    board.accept(rq);
    sent_cnt++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (board.pending_events.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic sched_req_t make_req(kind_e k, logic [15:0] el, logic [31:0] dl,
                                          logic [7:0] cd, logic [15:0] pr, logic fr);
    sched_req_t rq;
    rq.kind = k;
    rq.elapsed = el;
    rq.delay = dl;
    rq.code = cd;
    rq.param = pr;
    rq.frc = fr;
    return rq;
  endfunction

  // Random item, weighted toward schedules that expire and polls that drain them
  function automatic sched_req_t random_req();
    sched_req_t rq;
    int unsigned p;
    p = $urandom_range(0, 99);
    rq.elapsed = '0;
    rq.delay = '0;
    rq.frc = ($urandom_range(0, 3) == 0);
    rq.code = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    rq.param = 16'($urandom);
    if (p < poll_pct) begin
      rq.kind = KIND_POLL;
    end else if (p < poll_pct + 25) begin
      rq.kind = KIND_TICK;
      p = $urandom_range(0, 99);
      if (p < 5) rq.elapsed = '0;
      else if (p < 15) rq.elapsed = 16'($urandom);
      else rq.elapsed = 16'($urandom_range(1, 400));
    end else if (p < 90) begin
      rq.kind = KIND_SCHED;
      p = $urandom_range(0, 99);
      if (p < zero_delay_pct) rq.delay = '0;
      else if (p < 50) rq.delay = $urandom_range(1, 400);
      else if (p < 80) rq.delay = $urandom_range(1, 6000);
      else if (p < 96) rq.delay = $urandom_range(1, 300000);
      else rq.delay = $urandom;
    end else begin
      rq.kind = KIND_CANCEL;
    end
    return rq;
  endfunction

  // Cycle limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Take results, with random stalls and one long hold-off
  initial begin
    int unsigned stall;
    bit held;
    sched_res_t act;
    held = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && board.checked_cnt == 300) begin
        held = 1;
        stall = 500;
      end else begin
        stall = idle_draw(board.checked_cnt + 20);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(negedge clk_i);
      while (!out_valid_o) @(negedge clk_i);
      act.ev = ev_kind_e'(event_kind_o);
      act.code = out_code_o;
      act.param = out_param_o;
      act.status = status_e'(status_o);
      @(posedge clk_i);
      board.check(act);
    end
  end

  // Stimulus
  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_SHORT_LIM;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    kind_i        <= KIND_TICK;
    elapsed_ms_i  <= '0;
    delay_ms_i    <= '0;
    event_code_i  <= '0;
    event_param_i <= '0;
    force_req_i   <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, routing boundaries, cancel paths, empty and counted polls
    send_item(make_req(KIND_TICK, 16'd0, '0, '0, '0, 1'b0));
    send_item(make_req(KIND_POLL, '0, '0, '0, '0, 1'b0));
    send_item(make_req(KIND_SCHED, '0, 32'd0, 8'd255, 16'h8000, 1'b0));
    send_item(make_req(KIND_SCHED, '0, 32'd1, 8'd1, 16'h7fff, 1'b1));
    send_item(make_req(KIND_SCHED, '0, 32'd1999, 8'd2, 16'hffff, 1'b0));
    send_item(make_req(KIND_SCHED, '0, 32'd2000, 8'd3, 16'd5, 1'b0));
    send_item(make_req(KIND_SCHED, '0, 32'd59999, 8'd4, 16'd6, 1'b0));
    send_item(make_req(KIND_SCHED, '0, 32'd60000, 8'd5, 16'd7, 1'b0));
    send_item(make_req(KIND_SCHED, '0, 32'hffffffff, 8'd6, 16'd8, 1'b0));
    send_item(make_req(KIND_SCHED, '0, 32'd500, 8'd2, 16'd9, 1'b0));
    send_item(make_req(KIND_SCHED, '0, 32'd700, 8'd2, 16'd10, 1'b1));
    send_item(make_req(KIND_CANCEL, '0, '0, 8'd6, '0, 1'b0));
    send_item(make_req(KIND_CANCEL, '0, '0, 8'd200, '0, 1'b0));
    send_item(make_req(KIND_CANCEL, '0, '0, 8'd3, '0, 1'b1));
    send_item(make_req(KIND_TICK, 16'hffff, '0, '0, '0, 1'b0));
    repeat (8) send_item(make_req(KIND_POLL, '0, '0, '0, '0, 1'b0));
    send_item(make_req(KIND_TICK, 16'd1, '0, '0, '0, 1'b0));
    wait_idle();

    // Phases of register settings, extremes among them
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_reg(CFG_SHORT_LIM, 32'd1);
          write_reg(CFG_MED_LIM, 32'd1);
          write_reg(CFG_SEC_DAY, 32'd1);
          poll_pct = 40;
        end
        2: begin
          write_reg(CFG_SHORT_LIM, 32'd65535);
          write_reg(CFG_MED_LIM, 32'hffffffff);
          write_reg(CFG_SEC_DAY, 32'hffffffff);
          poll_pct = 30;
        end
        3: begin
          write_reg(CFG_SHORT_LIM, 32'd300);
          write_reg(CFG_MED_LIM, 32'd3000);
          write_reg(CFG_SEC_DAY, 32'd3);
          poll_pct = 12;
          zero_delay_pct = 40;
        end
        4: begin
          write_reg(CFG_SHORT_LIM, 32'd2000);
          write_reg(CFG_MED_LIM, 32'd60000);
          write_reg(CFG_SEC_DAY, 32'd86400);
          poll_pct = 35;
          zero_delay_pct = 10;
        end
        default: ;
      endcase
      for (int i = 0; i < 206; i++) begin
        // Hold the sender once until all results are back
        if (ph == 2 && i == 100) begin
          in_valid_i <= 1'b0;
          while (board.pending_events.size() != 0) @(posedge clk_i);
        end
        send_item(random_req());
      end
      wait_idle();
    end

    if (board.err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: delayed_event_timer_scheduler_core.f
design/detsch_pkg.sv
design/detsch_table.sv
design/detsch_div.sv
design/delayed_event_timer_scheduler_core.sv
sim/delayed_event_timer_scheduler_core_test.sv
